FILE: hw/rtl/ects_pkg.sv
// Shared types, constants and month table for the epoch seconds to calendar converter.
package ects_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;

  // reciprocal division: q = ((x >> Pre) * Recip) >> Post, exact over each input range
  localparam int unsigned DayPre    = 7;
  localparam int unsigned DayRecip  = 50903317;
  localparam int unsigned DayPost   = 35;
  localparam int unsigned HourPre   = 4;
  localparam int unsigned HourRecip = 9321;
  localparam int unsigned HourPost  = 21;
  localparam int unsigned MinPre    = 2;
  localparam int unsigned MinRecip  = 1093;
  localparam int unsigned MinPost   = 14;

  localparam int unsigned YearLen     = 365;
  localparam int unsigned LeapYearLen = 366;
  localparam int unsigned LeapCycle   = 400;
  localparam int unsigned Century     = 100;

  localparam int unsigned DataW   = 32;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned YearW   = 12;
  localparam int unsigned YearExtW = 13;
  localparam int unsigned PcW     = 4;
  localparam int unsigned OutW    = 38;
  localparam int unsigned OutBusW = 40;

  localparam logic [3:0] LastMonth = 4'd11;

  typedef enum logic [3:0] {
    OP_QUOT,
    OP_REM,
    OP_PUT_DAYS,
    OP_PUT_HOUR,
    OP_PUT_MIN,
    OP_LOAD_EPOCH,
    OP_MOD400,
    OP_MOD100,
    OP_PUT_C100,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } op_e;

  typedef enum logic [1:0] {
    K_DAY,
    K_HOUR,
    K_MIN
  } ksel_e;

  typedef struct packed {
    logic  en;
    op_e   op;
    ksel_e ksel;
  } ctrl_t;

  typedef struct packed {
    logic take;
    logic hold;
  } stat_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/epoch_seconds_to_calendar.sv
// Top level: converts seconds since a configurable epoch year into date and time.
//
// Input stream (s_axis_*): one request carries a 32-bit unsigned seconds count.
// Output stream (m_axis_*): one result per request with year, month (0 = Jan),
// day of month (0 based), hour, minute and second.
// Config: cfg_we_i writes cfg_wdata_i into the epoch year register (reset 1970);
// write it only while no request is in flight.
// Each request runs a 16-step microprogram: days, hours and minutes each take one
// reciprocal multiply, one multiply-subtract and one store (nine fixed steps), then
// the epoch is reduced mod 400 and mod 100 one subtraction per cycle, one looping
// step strips each whole year and another steps each month.
// One request is worked at a time; the next is taken only after the previous result
// is written to the output register.
// s_axis_tready is high whenever the sequencer is idle, also while a finished
// result waits in the output register. If the receiver stalls, the next
// request runs to its final step and waits there until the output register frees.
// Reset empties the output register, idles the sequencer and restores the epoch.
module epoch_seconds_to_calendar
  import ects_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DataW-1:0]     s_axis_tdata,   // [31:0] seconds
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutBusW-1:0]   m_axis_tdata,   // [11:0] year, [15:12] month, [20:16] day,
                                               // [25:21] hour, [31:26] minute,
                                               // [37:32] second, [39:38] zero
  input  logic                 cfg_we_i,
  input  logic [YearW-1:0]     cfg_wdata_i
);

  localparam logic [YearW-1:0] EpochReset = 12'd1970;

  logic             start;
  logic             busy;
  logic [YearW-1:0] epoch_year_q;
  ctrl_t            ctrl;
  stat_t            stat;
  logic [OutW-1:0]  out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_year_q <= EpochReset;
    end else if (cfg_we_i) begin
      epoch_year_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && !busy;

  ects_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  ects_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .seconds_i    (s_axis_tdata),
    .epoch_year_i (epoch_year_q),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (out_data)
  );

  assign m_axis_tdata = {(OutBusW - OutW)'(0), out_data};

endmodule

FILE: hw/rtl/ects_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module ects_seq
  import ects_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  typedef struct packed {
    op_e            op;
    ksel_e          ksel;
    logic           loop;
    logic [PcW-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_QUOT,       K_DAY,  1'b0, 4'd0};
      4'd1:    w = '{OP_REM,        K_DAY,  1'b0, 4'd0};
      4'd2:    w = '{OP_PUT_DAYS,   K_DAY,  1'b0, 4'd0};
      4'd3:    w = '{OP_QUOT,       K_HOUR, 1'b0, 4'd0};
      4'd4:    w = '{OP_REM,        K_HOUR, 1'b0, 4'd0};
      4'd5:    w = '{OP_PUT_HOUR,   K_HOUR, 1'b0, 4'd0};
      4'd6:    w = '{OP_QUOT,       K_MIN,  1'b0, 4'd0};
      4'd7:    w = '{OP_REM,        K_MIN,  1'b0, 4'd0};
      4'd8:    w = '{OP_PUT_MIN,    K_MIN,  1'b0, 4'd0};
      4'd9:    w = '{OP_LOAD_EPOCH, K_DAY,  1'b0, 4'd0};
      4'd10:   w = '{OP_MOD400,     K_DAY,  1'b1, 4'd10};
      4'd11:   w = '{OP_MOD100,     K_DAY,  1'b1, 4'd11};
      4'd12:   w = '{OP_PUT_C100,   K_DAY,  1'b0, 4'd0};
      4'd13:   w = '{OP_YEAR,       K_DAY,  1'b1, 4'd13};
      4'd14:   w = '{OP_MONTH,      K_DAY,  1'b1, 4'd14};
      default: w = '{OP_DONE,       K_DAY,  1'b0, 4'd0};
    endcase
    return w;
  endfunction

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  uword_t         word;

  assign word        = ucode(pc_q);
  assign ctrl_o.en   = busy_q && !stat_i.hold;
  assign ctrl_o.op   = word.op;
  assign ctrl_o.ksel = word.ksel;
  assign busy_o      = busy_q;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (ctrl_o.en) begin
      if (word.op == OP_DONE) begin
        busy_d = 1'b0;
      end
      pc_d = (word.loop && stat_i.take) ? word.target : pc_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

`ifndef SYNTHESIS
  a_start_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && pc_q == '0)
    else $error("sequencer did not restart at step zero");

  a_hold_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && stat_i.hold |=> $stable(pc_q) && busy_q)
    else $error("step counter moved while output stalled");

  a_end_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(word.op) == OP_DONE)
    else $error("sequencer went idle outside the final step");
`endif

endmodule

FILE: hw/rtl/ects_dp.sv
// Datapath: reciprocal multiplier, shared subtractor, year and month registers, output register.
module ects_dp
  import ects_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DataW-1:0]   seconds_i,
  input  logic [YearW-1:0]   epoch_year_i,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [OutW-1:0]    out_data_o
);

  logic [DataW-1:0]    a_q;
  logic [DaysW-1:0]    q_q;
  logic [DaysW-1:0]    dn_q;
  logic [YearExtW-1:0] year_q;
  logic [6:0]          c100_q;
  logic [1:0]          cen_q;
  logic [3:0]          month_q;
  logic [4:0]          hour_q;
  logic [5:0]          minute_q;
  logic [5:0]          second_q;
  logic                out_valid_q;
  logic [OutW-1:0]     out_data_q;

  logic               leap;
  logic [DataW-1:0]   pre_x, recip, divisor, mul_x, mul_k;
  logic [2*DataW-1:0] prod;
  logic [DaysW-1:0]   quot;
  logic [DataW-1:0]   sub_a, sub_b;
  logic [DataW:0]     diff;
  logic               ge;
  logic               take;

  // leap: divisible by 4, and not a century unless the century count is a multiple of 4
  assign leap = (year_q[1:0] == 2'b00) && (c100_q != 7'd0 || cen_q == 2'd0);

  // quotient step multiplies by the reciprocal, remainder step by the divisor
  always_comb begin
    case (ctrl_i.ksel)
      K_HOUR: begin
        pre_x   = a_q >> HourPre;
        recip   = DataW'(HourRecip);
        divisor = DataW'(SecsPerHour);
      end
      K_MIN: begin
        pre_x   = a_q >> MinPre;
        recip   = DataW'(MinRecip);
        divisor = DataW'(SecsPerMin);
      end
      default: begin
        pre_x   = a_q >> DayPre;
        recip   = DataW'(DayRecip);
        divisor = DataW'(SecsPerDay);
      end
    endcase
    mul_x = (ctrl_i.op == OP_REM) ? DataW'(q_q) : pre_x;
    mul_k = (ctrl_i.op == OP_REM) ? divisor : recip;
    prod  = {{DataW{1'b0}}, mul_x} * {{DataW{1'b0}}, mul_k};
    case (ctrl_i.ksel)
      K_HOUR:  quot = DaysW'(prod >> HourPost);
      K_MIN:   quot = DaysW'(prod >> MinPost);
      default: quot = DaysW'(prod >> DayPost);
    endcase
  end

  always_comb begin
    sub_a = (ctrl_i.op == OP_YEAR || ctrl_i.op == OP_MONTH) ? DataW'(dn_q) : a_q;
    case (ctrl_i.op)
      OP_REM:      sub_b = prod[DataW-1:0];
      OP_MOD400:   sub_b = DataW'(LeapCycle);
      OP_MOD100:   sub_b = DataW'(Century);
      OP_YEAR:     sub_b = leap ? DataW'(LeapYearLen) : DataW'(YearLen);
      OP_MONTH:    sub_b = DataW'(month_len(leap, month_q));
      default:     sub_b = '0;
    endcase
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[DataW];
    case (ctrl_i.op)
      OP_MOD400,
      OP_MOD100,
      OP_YEAR:     take = ge;
      OP_MONTH:    take = ge && (month_q != LastMonth);
      default:     take = 1'b0;
    endcase
  end

  assign stat_o.take = take;
  assign stat_o.hold = (ctrl_i.op == OP_DONE) && out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= seconds_i;
    end else if (ctrl_i.en) begin
      case (ctrl_i.op)
        OP_QUOT: q_q <= quot;
        OP_REM:  a_q <= diff[DataW-1:0];
        OP_PUT_DAYS: dn_q <= q_q;
        OP_PUT_HOUR: hour_q <= q_q[4:0];
        OP_PUT_MIN: begin
          minute_q <= q_q[5:0];
          second_q <= a_q[5:0];
        end
        OP_LOAD_EPOCH: begin
          a_q    <= DataW'(epoch_year_i);
          year_q <= YearExtW'(epoch_year_i);
          cen_q  <= 2'd0;
        end
        OP_MOD400: begin
          if (ge) begin
            a_q <= diff[DataW-1:0];
          end
        end
        OP_MOD100: begin
          if (ge) begin
            a_q   <= diff[DataW-1:0];
            cen_q <= cen_q + 2'd1;
          end
        end
        OP_PUT_C100: begin
          c100_q  <= a_q[6:0];
          month_q <= 4'd0;
        end
        OP_YEAR: begin
          if (ge) begin
            dn_q   <= diff[DaysW-1:0];
            year_q <= year_q + YearExtW'(1);
            if (c100_q == 7'(Century - 1)) begin
              c100_q <= 7'd0;
              cen_q  <= cen_q + 2'd1;
            end else begin
              c100_q <= c100_q + 7'd1;
            end
          end
        end
        OP_MONTH: begin
          if (take) begin
            dn_q    <= diff[DaysW-1:0];
            month_q <= month_q + 4'd1;
          end
        end
        OP_DONE: begin
          out_data_q <= {second_q, minute_q, hour_q, dn_q[4:0], month_q,
                         year_q[YearW-1:0]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.en && ctrl_i.op == OP_DONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q[15:12] <= LastMonth)
    else $error("month out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q[25:21] < 5'd24 && out_data_q[31:26] < 6'd60
                    && out_data_q[37:32] < 6'd60)
    else $error("time of day out of range");
`endif

endmodule
